/* src/hace_pkg.sv */
`default_nettype none
package hace_pkg;

  // One input beat: a screen byte and its end-of-row mark.
  typedef struct packed {
    logic [7:0] screen_byte;
    logic       row_end;
  } in_beat_t;

  // One result beat: seven RGB pixels, leftmost first, and the row mark.
  typedef struct packed {
    logic [23:0] pixel_0;
    logic [23:0] pixel_1;
    logic [23:0] pixel_2;
    logic [23:0] pixel_3;
    logic [23:0] pixel_4;
    logic [23:0] pixel_5;
    logic [23:0] pixel_6;
    logic        row_done;
  } out_beat_t;

  // One byte ready for expansion, with the neighbor state it needs.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       right_bit;
    logic       left_bit;
    logic       parity;
    logic       done;
  } job_t;

  // Up to two jobs handed from the front end to the queue in one cycle.
  // When only one job is pushed it is always in slot a.
  typedef struct packed {
    logic push_a;
    logic push_b;
    job_t job_a;
    job_t job_b;
  } push_t;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PixelsPerByte = 7;

  // Window codes that take artifact colors; odd parity trades them.
  localparam logic [2:0] WIN_ART_A = 3'b010;
  localparam logic [2:0] WIN_ART_B = 3'b101;
  localparam logic [2:0] WIN_FLIP  = 3'b111;

  localparam logic [23:0] RGB_BLACK  = 24'h000000;
  localparam logic [23:0] RGB_WHITE  = 24'hFFFFFF;
  localparam logic [23:0] RGB_VIOLET = 24'hC734FF;
  localparam logic [23:0] RGB_GREEN  = 24'h38CB00;
  localparam logic [23:0] RGB_BLUE   = 24'h0DA1FF;
  localparam logic [23:0] RGB_ORANGE = 24'hF25E00;

  // Palette lookup for a 3-bit window (bit 0 left, bit 1 self, bit 2 right).
  function automatic logic [23:0] window_rgb(input logic phase, input logic [2:0] win);
    logic [23:0] rgb;
    case (win)
      3'd3, 3'd6, 3'd7: rgb = RGB_WHITE;
      WIN_ART_A:        rgb = phase ? RGB_BLUE : RGB_VIOLET;
      WIN_ART_B:        rgb = phase ? RGB_ORANGE : RGB_GREEN;
      default:          rgb = RGB_BLACK;
    endcase
    return rgb;
  endfunction

endpackage
`default_nettype wire

/* src/hace_front.sv */
`default_nettype none
module hace_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hace_pkg::in_beat_t in_beat,
  input  wire logic               room,
  output hace_pkg::push_t         push
);

  logic [7:0] held_byte;
  logic       held_valid;
  logic       left_bit;
  logic       column_parity;

  logic       accept;
  logic       left_mid;
  logic       parity_mid;
  hace_pkg::job_t held_job;
  hace_pkg::job_t end_job;

  assign in_ready = room;
  assign accept   = in_valid && room;

  // Release of the held byte uses the new byte's bit 0 as its right neighbor.
  always_comb begin
    held_job.byte_val  = held_byte;
    held_job.right_bit = in_beat.screen_byte[0];
    held_job.left_bit  = left_bit;
    held_job.parity    = column_parity;
    held_job.done      = 1'b0;
    left_mid   = held_valid ? held_byte[6] : left_bit;
    parity_mid = held_valid ? ~column_parity : column_parity;
    end_job.byte_val  = in_beat.screen_byte;
    end_job.right_bit = 1'b0;
    end_job.left_bit  = left_mid;
    end_job.parity    = parity_mid;
    end_job.done      = 1'b1;
  end

  // Pack the jobs so that a single job always sits in slot a.
  always_comb begin
    push.push_a = accept && (held_valid || in_beat.row_end);
    push.push_b = accept && held_valid && in_beat.row_end;
    push.job_a  = held_valid ? held_job : end_job;
    push.job_b  = end_job;
  end

  // Hold one byte back and track left bit and parity across the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid    <= 1'b0;
      held_byte     <= '0;
      left_bit      <= 1'b0;
      column_parity <= 1'b0;
    end else if (accept) begin
      if (in_beat.row_end) begin
        held_valid    <= 1'b0;
        held_byte     <= '0;
        left_bit      <= 1'b0;
        column_parity <= 1'b0;
      end else begin
        held_valid    <= 1'b1;
        held_byte     <= in_beat.screen_byte;
        left_bit      <= left_mid;
        column_parity <= parity_mid;
      end
    end
  end

endmodule
`default_nettype wire

/* src/hace_queue.sv */
`default_nettype none
module hace_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire hace_pkg::push_t push,
  output logic                 room,
  output logic                 head_valid,
  output hace_pkg::job_t       head,
  input  wire logic            pop
);

  localparam int unsigned PtrW = $clog2(hace_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(hace_pkg::QueueDepth + 1);

  hace_pkg::job_t entries [hace_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic [PtrW-1:0] wr_ptr_b;
  logic [CntW-1:0] n_push;

  // Room means at least two free slots, enough for the worst case of one input beat.
  assign room       = count <= CntW'(hace_pkg::QueueDepth - 2);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign wr_ptr_b   = wr_ptr + PtrW'(1);
  assign n_push     = CntW'(push.push_a) + CntW'(push.push_b);
  assign count_next = count + n_push - CntW'(pop);

  // Storage writes: slot a at the write pointer, slot b just after it.
  always_ff @(posedge clk) begin
    if (push.push_a) begin
      entries[wr_ptr] <= push.job_a;
    end
    if (push.push_b) begin
      entries[wr_ptr_b] <= push.job_b;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

/* src/hace_back.sv */
`default_nettype none
module hace_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           mono_mode,
  input  wire logic           head_valid,
  input  wire hace_pkg::job_t head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output hace_pkg::out_beat_t out_beat
);

  logic [8:0]  stream;
  logic [23:0] px [hace_pkg::PixelsPerByte];
  logic [2:0]  win;
  logic        par;
  hace_pkg::out_beat_t beat_next;

  assign pop    = head_valid && (!out_valid || out_ready);
  assign stream = {head.right_bit, head.byte_val[6:0], head.left_bit};

  // Expand each pixel from its three-bit window, or plain mono.
  always_comb begin
    for (int i = 0; i < hace_pkg::PixelsPerByte; i++) begin
      win = stream[i +: 3];
      par = head.parity ^ i[0];
      if (par && (win == hace_pkg::WIN_ART_A || win == hace_pkg::WIN_ART_B)) begin
        win = win ^ hace_pkg::WIN_FLIP;
      end
      if (mono_mode) begin
        px[i] = head.byte_val[i] ? hace_pkg::RGB_WHITE : hace_pkg::RGB_BLACK;
      end else begin
        px[i] = hace_pkg::window_rgb(head.byte_val[7], win);
      end
    end
  end

  always_comb begin
    beat_next.pixel_0  = px[0];
    beat_next.pixel_1  = px[1];
    beat_next.pixel_2  = px[2];
    beat_next.pixel_3  = px[3];
    beat_next.pixel_4  = px[4];
    beat_next.pixel_5  = px[5];
    beat_next.pixel_6  = px[6];
    beat_next.row_done = head.done;
  end

  // Output register: loads a new beat whenever it is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_beat <= beat_next;
    end
  end

endmodule
`default_nettype wire

/* src/hires_artifact_color_expander_top.sv */
// Hi-res scanline expander: screen bytes in, seven RGB pixels per byte out.
// Input channel (in_valid/in_ready/in_beat) takes one screen byte per beat,
// with row_end set on the last byte of a scanline. Output channel
// (out_valid/out_ready/out_beat) gives one beat per byte, pixel_0 leftmost,
// row_done set on the beat of the row's last byte.
// A byte is held back until the next byte arrives, since its last pixel
// needs that byte's bit 0. Its job enters the queue when that byte is
// accepted, and out_valid rises once it is loaded into the output register.
// A row_end byte with nothing held takes the same path. When a held byte
// goes out in the same input beat, both jobs enter the queue together and
// the row_end byte's beat comes straight after the held byte's beat.
// Throughput is one beat per cycle unless out_ready stalls; the four-entry
// job queue between the front end and the expander takes up to two jobs
// in a cycle, and in_ready is high while at least two entries are free.
// cfg_we/cfg_data write mono_mode (1 = white/black pixels, 0 = artifact
// color); write it only while the block is idle.
// Synchronous reset clears the held byte, left bit, parity, queue, output
// register and mono_mode. When the receiver stalls, the output beat holds,
// the queue fills, and in_ready drops until room opens again.
`default_nettype none
module hires_artifact_color_expander_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire hace_pkg::in_beat_t  in_beat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hace_pkg::out_beat_t      out_beat
);

  logic            mono_mode;
  logic            room;
  logic            head_valid;
  logic            pop;
  hace_pkg::push_t push;
  hace_pkg::job_t  head;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mono_mode <= 1'b0;
    end else if (cfg_we) begin
      mono_mode <= cfg_data;
    end
  end

  hace_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .room     (room),
    .push     (push)
  );

  hace_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  hace_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mono_mode  (mono_mode),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_beat)
  );

endmodule
`default_nettype wire
